>>> design/ism_pkg.sv
// Package for the interval statistics monitor: widths, limits, the
// controller state type and the controller-to-datapath command struct.
// No dependencies.
package ism_pkg;

   localparam int STAMP_W  = 32;
   localparam int SAMPLE_W = 16;
   localparam int STEP_W   = 4;

   localparam logic [SAMPLE_W-1:0] SAMPLE_LIMIT = 16'hFFFF;
   localparam logic [STEP_W-1:0]   LAST_STEP    = 4'hF;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_LOAD = 3'b100
   } state_type;

   typedef struct packed {
      logic update;    // take the item, update statistics, seed divider
      logic div_step;  // one restoring divide step
      logic out_load;  // copy results into the output register
   } cmd_type;

endpackage

>>> design/ism_if.sv
// Valid/ready channel interfaces for request and response items.
// Depends on ism_pkg.
interface ism_req_if;
   import ism_pkg::*;
   logic                valid;
   logic                ready;
   logic [STAMP_W-1:0]  timestamp_us;

   modport source (output valid, output timestamp_us, input ready);
   modport sink   (input valid, input timestamp_us, output ready);
endinterface

interface ism_rsp_if;
   import ism_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] last_interval;
   logic [SAMPLE_W-1:0] average_interval;
   logic [SAMPLE_W-1:0] max_interval;
   logic [SAMPLE_W-1:0] sample_count;

   modport source (output valid, output last_interval, output average_interval,
                   output max_interval, output sample_count, input ready);
   modport sink   (input valid, input last_interval, input average_interval,
                   input max_interval, input sample_count, output ready);
endinterface

>>> design/ism_dp.sv
// Datapath: interval statistics registers, radix-2 divider, result register.
// Depends on ism_pkg.
module ism_dp
   import ism_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic [STAMP_W-1:0]  timestamp_us,
   output logic [SAMPLE_W-1:0] last_interval,
   output logic [SAMPLE_W-1:0] average_interval,
   output logic [SAMPLE_W-1:0] max_interval,
   output logic [SAMPLE_W-1:0] sample_count
);

   logic [STAMP_W-1:0]  prev_ff, prev_in;
   logic [SAMPLE_W-1:0] total_ff, total_in;
   logic [SAMPLE_W-1:0] tally_ff, tally_in;
   logic [SAMPLE_W-1:0] peak_ff, peak_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   // divider: remainder, quotient (holds dividend at start), divisor
   logic [SAMPLE_W-1:0] rem_ff, rem_in;
   logic [SAMPLE_W-1:0] quo_ff, quo_in;
   logic [SAMPLE_W-1:0] div_ff, div_in;
   logic [SAMPLE_W-1:0] last_ff, avg_ff, max_ff, count_ff;

   logic [STAMP_W-1:0]  elapsed;
   logic [SAMPLE_W-1:0] sample;
   logic [SAMPLE_W-1:0] tally_sat;
   logic [SAMPLE_W:0]   rem_shift;
   logic [SAMPLE_W:0]   rem_diff;

   assign elapsed   = timestamp_us - prev_ff;
   assign sample    = (|elapsed[STAMP_W-1:SAMPLE_W]) ? SAMPLE_LIMIT
                                                    : elapsed[SAMPLE_W-1:0];
   assign tally_sat = (tally_ff != SAMPLE_LIMIT) ? tally_ff + 16'd1 : tally_ff;

   assign rem_shift = {rem_ff, quo_ff[SAMPLE_W-1]};
   assign rem_diff  = rem_shift - {1'b0, div_ff};

   always_comb begin
      prev_in   = prev_ff;
      total_in  = total_ff;
      tally_in  = tally_ff;
      peak_in   = peak_ff;
      sample_in = sample_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      div_in    = div_ff;
      if (cmd.update) begin
         prev_in   = timestamp_us;
         sample_in = sample;
         if (total_ff < (SAMPLE_LIMIT - sample)) begin
            total_in = total_ff + sample;
            tally_in = tally_sat;
         end else begin
            total_in = sample;
            tally_in = 16'd1;
         end
         if (sample > peak_ff) begin
            peak_in = sample;
         end
         rem_in = '0;
         quo_in = total_in;
         div_in = tally_in;
      end else if (cmd.div_step) begin
         if (!rem_diff[SAMPLE_W]) begin
            rem_in = rem_diff[SAMPLE_W-1:0];
            quo_in = {quo_ff[SAMPLE_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[SAMPLE_W-1:0];
            quo_in = {quo_ff[SAMPLE_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         total_ff <= '0;
         tally_ff <= '0;
         peak_ff  <= '0;
      end else begin
         prev_ff  <= prev_in;
         total_ff <= total_in;
         tally_ff <= tally_in;
         peak_ff  <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      div_ff    <= div_in;
      if (cmd.out_load) begin
         last_ff  <= sample_ff;
         avg_ff   <= quo_ff;
         max_ff   <= peak_ff;
         count_ff <= tally_ff;
      end
   end

   assign last_interval    = last_ff;
   assign average_interval = avg_ff;
   assign max_interval     = max_ff;
   assign sample_count     = count_ff;

endmodule

>>> design/ism_ctrl.sv
// Controller: sequences accept, sixteen divide steps and the result load;
// owns the request ready and response valid. Depends on ism_pkg.
module ism_ctrl
   import ism_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.update = 1'b1;
               step_in    = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 4'd1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> design/interval_statistics_monitor_top.sv
// Top level of the interval statistics monitor: joins controller and datapath
// to the request and response channels. Depends on ism_pkg, ism_if, ism_ctrl, ism_dp.
//
//   channel | dir | payload                                         | handshake
//   req_if  | in  | timestamp_us[31:0]                              | valid/ready
//   rsp_if  | out | last_interval, average_interval, max_interval,  | valid/ready
//           |     | sample_count (16 bits each)                     |
//
// Each item is handled in order: take the timestamp and update the window statistics,
// run the restoring radix-2 divide of sum by count one quotient bit per step, then
// load the output register once the response side is free.
// Reset is synchronous: previous timestamp, sum, count and maximum go to zero.
// A result waiting in the output register does not block the next item; only
// the load of a following result waits for rsp_if.ready.
module interval_statistics_monitor_top
   import ism_pkg::*;
(
   input logic      clock,
   input logic      reset,
   ism_req_if.sink  req_if,
   ism_rsp_if.source rsp_if
);

   cmd_type cmd;

   // sequencing: ready in idle, divide steps, gated result load
   ism_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   // statistics, divider and result register
   ism_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .timestamp_us     (req_if.timestamp_us),
      .last_interval    (rsp_if.last_interval),
      .average_interval (rsp_if.average_interval),
      .max_interval     (rsp_if.max_interval),
      .sample_count     (rsp_if.sample_count)
   );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for interval_statistics_monitor_top.
// Timestamps in, interval reports out. Depends on ism_pkg, ism_if and the files under design/.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ism_pkg::*;

   // Generous ceiling on the run length of a correct run, stall phases included.
   localparam int unsigned CYCLE_LIMIT = 400_000;
   localparam int unsigned ZERO_RUN = 200;
   localparam int unsigned DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [SAMPLE_W-1:0] last_interval;
      logic [SAMPLE_W-1:0] average_interval;
      logic [SAMPLE_W-1:0] max_interval;
      logic [SAMPLE_W-1:0] sample_count;
   } interval_report_type;

   logic clock;
   logic reset;

   ism_req_if req_ch ();
   ism_rsp_if rsp_ch ();

   interval_statistics_monitor_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch.sink),
      .rsp_if (rsp_ch.source)
   );

   // Shadow copy of the window state. It is updated at the edge where an item is accepted.
   logic [STAMP_W-1:0]  window_prev_stamp;
   logic [SAMPLE_W-1:0] window_total;
   logic [SAMPLE_W-1:0] window_count;
   logic [SAMPLE_W-1:0] window_peak;

   interval_report_type pending_reports[$];

   int unsigned send_idle_pct;       // chance in 100 that the sender idles in a given cycle
   int unsigned recv_stall_pct;      // chance in 100 that the receiver stalls in a given cycle
   int unsigned report_hold_cycles;  // long receiver hold-off, counted down below
   int unsigned cycle_count;
   int unsigned error_count;
   int unsigned stamps_sent;
   int unsigned reports_checked;
   int unsigned window_restarts;
   int unsigned longest_window;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Expected report for one timestamp. The window state moves on as a side effect.
   function automatic interval_report_type advance_interval_stats(
      input logic [STAMP_W-1:0] stamp);
      logic [STAMP_W-1:0]  elapsed;
      logic [SAMPLE_W-1:0] sample;
      logic [SAMPLE_W:0]   sum_wide;
      interval_report_type report;
      elapsed = stamp - window_prev_stamp;   // modulo 2^32, so wrap comes for free
      sample = (elapsed > {{(STAMP_W-SAMPLE_W){1'b0}}, SAMPLE_LIMIT}) ?
               SAMPLE_LIMIT : elapsed[SAMPLE_W-1:0];
      if (window_count < SAMPLE_LIMIT) begin
         window_count = window_count + 1'b1;
      end
      // total < limit - sample, written without the subtraction
      sum_wide = {1'b0, window_total} + {1'b0, sample};
      if (sum_wide < {1'b0, SAMPLE_LIMIT}) begin
         window_total = sum_wide[SAMPLE_W-1:0];
      end else begin
         window_count = 16'd1;
         window_total = sample;
         window_restarts++;
      end
      if (sample > window_peak) begin
         window_peak = sample;
      end
      window_prev_stamp = stamp;
      report.last_interval    = sample;
      report.average_interval = (window_count != 0) ? window_total / window_count : '0;
      report.max_interval     = window_peak;
      report.sample_count     = window_count;
      return report;
   endfunction

   // One item on the request channel. Valid stays high after acceptance, so back-to-back
   // items never drop it. An idle gap lowers it at the falling edge that follows.
   task automatic send_stamp(input logic [STAMP_W-1:0] stamp);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.timestamp_us <= stamp;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      pending_reports.push_back(advance_interval_stats(stamp));
      stamps_sent++;
   endtask

   task automatic send_interval(input logic [STAMP_W-1:0] delta);
      send_stamp(window_prev_stamp + delta);
   endtask

   // Half are zero or short intervals, so windows build up over many samples. The rest are
   // wide-range, near-limit, clamped, absolute random stamps (these toggle every bit), jumps
   // close to the top of the range so that later short steps wrap, and steps at the sum boundary.
   function automatic logic [STAMP_W-1:0] random_stamp();
      logic [STAMP_W-1:0] stamp;
      case ($urandom_range(11))
         0:       stamp = window_prev_stamp;
         1, 2, 3: stamp = window_prev_stamp + $urandom_range(300);
         4, 5:    stamp = window_prev_stamp + $urandom_range(3000);
         6:       stamp = window_prev_stamp + $urandom_range(65535);
         7:       stamp = window_prev_stamp + SAMPLE_LIMIT - $urandom_range(3);
         8:       stamp = window_prev_stamp + 32'h0001_0000 + $urandom;
         9:       stamp = $urandom;
         10:      stamp = 32'hFFFF_FFFF - $urandom_range(2000);
         default: stamp = window_prev_stamp + (SAMPLE_LIMIT - window_total)
                          - $urandom_range(1);  // right at the sum boundary
      endcase
      return stamp;
   endfunction

   // ---------------------------------------------------------------- receiver
   // Ready changes at the falling edge. A hold-off request overrides the random stalls.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (report_hold_cycles != 0) begin
            rsp_ch.ready <= 1'b0;
            report_hold_cycles--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------- checker
   task automatic check_field(input string field, input logic [SAMPLE_W-1:0] want,
                              input logic [SAMPLE_W-1:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      interval_report_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_reports.size() == 0) begin
            error_count++;
            $display("%0t ns: unexpected report, expected none, actual %0d/%0d/%0d/%0d",
                     $time, rsp_ch.last_interval, rsp_ch.average_interval,
                     rsp_ch.max_interval, rsp_ch.sample_count);
         end else begin
            want = pending_reports.pop_front();
            check_field("last_interval", want.last_interval, rsp_ch.last_interval);
            check_field("average_interval", want.average_interval, rsp_ch.average_interval);
            check_field("max_interval", want.max_interval, rsp_ch.max_interval);
            check_field("sample_count", want.sample_count, rsp_ch.sample_count);
            reports_checked++;
            if (want.sample_count > longest_window) begin
               longest_window = want.sample_count;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests
   // The very first item after reset measures from zero.
   task automatic test_first_item_from_zero();
      send_stamp(32'h0000_2A10);
   endtask

   // Sum boundary. A sum landing at 65534 still fits, one more restarts, and an exact
   // fill restarts too.
   task automatic test_window_boundaries();
      send_interval(0);
      send_interval(1);
      send_interval(SAMPLE_LIMIT - window_total - 1);
      send_interval(1);
      send_interval(SAMPLE_LIMIT - window_total);
      send_interval(0);
      send_interval(7);
   endtask

   // Zero intervals never grow the sum, so the count climbs over a long window.
   // After that, a short step and then a full-limit sample force a restart.
   task automatic test_count_growth();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (ZERO_RUN) send_interval(0);
      send_interval(3);
      send_interval(SAMPLE_LIMIT);
      send_interval(2);
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering items. The
   // output register and the item in the divider fill, and req ready must drop.
   task automatic test_backpressure();
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      report_hold_cycles = 400;
      repeat (12) send_interval($urandom_range(2000));
   endtask

   // Full-limit sample, zero after a full sum, clamping, backward steps, a small wrap across
   // 2^32, and stamps that set and clear every bit.
   task automatic test_long_and_wrapped_intervals();
      send_interval(SAMPLE_LIMIT);
      send_interval(0);
      send_interval(32'h0001_0000);
      send_interval(32'hFFFF_FFFF);
      send_stamp(32'hFFFF_FFF0);
      send_stamp(32'h0000_0010);
      send_stamp(32'hAAAA_AAAA);
      send_stamp(32'h5555_5555);
      send_stamp(32'hFFFF_FFFF);
      send_stamp(32'h0000_0000);
   endtask

   task automatic test_random_phase(input int unsigned count, input int unsigned idle_pct,
                                    input int unsigned stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_stamp(random_stamp());
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.timestamp_us = '0;
      window_prev_stamp   = '0;
      window_total        = '0;
      window_count        = '0;
      window_peak         = '0;
      send_idle_pct       = 0;
      recv_stall_pct      = 0;
      report_hold_cycles  = 0;
      cycle_count         = 0;
      error_count         = 0;
      stamps_sent         = 0;
      reports_checked     = 0;
      window_restarts     = 0;
      longest_window      = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_first_item_from_zero();
      test_window_boundaries();
      test_count_growth();
      test_backpressure();
      test_long_and_wrapped_intervals();
      test_random_phase(320, 0, 0);
      test_random_phase(300, 87, 0);
      test_random_phase(300, 0, 87);
      test_random_phase(300, 7, 7);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      // Extra cycles to catch any stray report after the last expected one.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d timestamps, checked %0d reports; %0d window restarts.",
               stamps_sent, reports_checked, window_restarts);
      $display("Longest averaging window reached %0d samples; mismatches: %0d.",
               longest_window, error_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
design/ism_pkg.sv
design/ism_if.sv
design/ism_dp.sv
design/ism_ctrl.sv
design/interval_statistics_monitor_top.sv
tb/testbench.sv
